// File: rtl/feedback_stream_decryptor_macros.svh
// Assertion macros for the feedback stream decryptor.
// Used by the top level; expects clk and arst_n in the including scope.
`ifndef FEEDBACK_STREAM_DECRYPTOR_MACROS_SVH
`define FEEDBACK_STREAM_DECRYPTOR_MACROS_SVH

`ifndef SYNTHESIS
`define FSD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fsd: same-cycle check failed");
`define FSD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fsd: next-cycle check failed");
`else
`define FSD_ASSERT_IMP(lbl, ante, cons)
`define FSD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: rtl/fsd_pkg.sv
// Shared types and constants for the feedback stream decryptor.
// No dependencies; imported by every module of the block.
package fsd_pkg;

	localparam int RING_DEPTH  = 32;
	localparam int RING_IDX_W  = $clog2(RING_DEPTH);
	localparam int WORD_BYTES  = 8;
	localparam int BIW_W       = $clog2(WORD_BYTES);
	localparam int KEY_WORDS   = RING_DEPTH / WORD_BYTES;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = QPTR_W + 1;

	localparam logic [63:0] LCG_MUL = 64'd2862933555777941757;
	localparam logic [63:0] LCG_ADD = 64'd7046029254386353087;
	localparam logic [31:0] MWC_MUL = 32'd4294957665;
	localparam logic [63:0] XS_INIT = 64'd4101842887655102017;

	typedef enum logic {
		OP_RESTART = 1'b0,
		OP_DECRYPT = 1'b1
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
	} cmd_t;

	typedef enum logic [2:0] {
		REG_KEY0  = 3'd0,
		REG_KEY1  = 3'd1,
		REG_KEY2  = 3'd2,
		REG_KEY3  = 3'd3,
		REG_TWEAK = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		G_IDLE,
		G_P0,
		G_P1,
		G_P2,
		G_P3,
		G_P4,
		G_P5
	} gen_state_t;

	typedef struct packed {
		logic start;
		logic seed_load;
	} gen_req_t;

	typedef struct packed {
		logic       busy;
		logic       seeding;
		logic [7:0] ks_byte;
	} gen_stat_t;

	typedef logic [KEY_WORDS-1:0][63:0] key_arr_t;

endpackage

// File: rtl/fsd_front.sv
// Input side: accepts items, tags them restart or decrypt, queues them.
// Depends on fsd_pkg.
module fsd_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [7:0]    s_tdata,   // [7:0] cipher_byte
	input  logic          s_tuser,   // [0] action
	output logic          head_valid,
	output fsd_pkg::cmd_t head,
	input  logic          pop
);
	import fsd_pkg::*;

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              take;
	cmd_t              cmd;

	assign s_tready   = count_q != QCNT_W'(QUEUE_DEPTH);
	assign push       = s_tvalid && s_tready;
	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_ptr_q];
	assign take       = pop && head_valid;

	always_comb begin
		cmd.op   = op_t'(s_tuser);
		cmd.data = s_tdata;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (take) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !take) begin
				count_q <= count_q + 1'b1;
			end else if (take && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/fsd_gen.sv
// Keystream generator: LCG, xorshift and multiply-with-carry, the LCG and MWC on one shared
// 32x32 multiplier stepped through states P0 to P5. Depends on fsd_pkg.
module fsd_gen (
	input  logic               clk,
	input  logic               arst_n,
	input  fsd_pkg::gen_req_t  req,
	input  logic [63:0]        seed,
	input  logic [7:0]         first_ks,
	output fsd_pkg::gen_stat_t stat
);
	import fsd_pkg::*;

	gen_state_t  state_q;
	gen_state_t  state_d;
	logic [63:0] lcg_q;
	logic [63:0] xs_q;
	logic [63:0] mwc_q;
	logic [1:0]  seed_cnt_q;
	logic [7:0]  ks_q;
	logic [63:0] prod_q;
	logic [63:0] acc_q;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] mul_p;
	logic [63:0] xs_t1;
	logic [63:0] xs_t2;
	logic [63:0] xs_next;
	logic [63:0] x1;
	logic [63:0] x2;
	logic [63:0] x3;
	logic [7:0]  res_byte;

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			G_P0: begin
				mul_a = lcg_q[31:0];
				mul_b = LCG_MUL[31:0];
			end
			G_P1: begin
				mul_a = lcg_q[31:0];
				mul_b = LCG_MUL[63:32];
			end
			G_P2: begin
				mul_a = lcg_q[63:32];
				mul_b = LCG_MUL[31:0];
			end
			G_P3: begin
				mul_a = mwc_q[31:0];
				mul_b = MWC_MUL;
			end
			G_IDLE, G_P4, G_P5: begin
			end
			default: begin
			end
		endcase
		mul_p = {32'b0, mul_a} * {32'b0, mul_b};
	end

	always_comb begin
		xs_t1   = xs_q ^ (xs_q >> 17);
		xs_t2   = xs_t1 ^ (xs_t1 << 31);
		xs_next = xs_t2 ^ (xs_t2 >> 8);
		x1      = lcg_q ^ (lcg_q << 21);
		x2      = x1 ^ (x1 >> 35);
		x3      = x2 ^ (x2 << 4);
		// only the low byte of the word is ever used
		res_byte = (x3[7:0] + xs_q[7:0]) ^ mwc_q[7:0];
	end

	always_comb begin
		state_d = state_q;
		if (req.seed_load) begin
			state_d = G_P0;
		end else begin
			unique case (state_q)
				G_IDLE:  state_d = req.start ? G_P0 : G_IDLE;
				G_P0:    state_d = G_P1;
				G_P1:    state_d = G_P2;
				G_P2:    state_d = G_P3;
				G_P3:    state_d = G_P4;
				G_P4:    state_d = G_P5;
				G_P5:    state_d = (seed_cnt_q > 2'd1) ? G_P0 : G_IDLE;
				default: state_d = G_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= G_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			G_P0: begin
				prod_q <= mul_p;
			end
			G_P1: begin
				acc_q  <= prod_q;
				prod_q <= mul_p;
			end
			G_P2, G_P3: begin
				acc_q  <= acc_q + {prod_q[31:0], 32'b0};
				prod_q <= mul_p;
			end
			G_IDLE, G_P4, G_P5: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcg_q      <= '0;
			xs_q       <= '0;
			mwc_q      <= '0;
			seed_cnt_q <= '0;
			ks_q       <= '0;
		end else if (req.seed_load) begin
			lcg_q      <= XS_INIT ^ seed;
			xs_q       <= XS_INIT;
			mwc_q      <= 64'd1;
			seed_cnt_q <= 2'd3;
			ks_q       <= first_ks;
		end else begin
			unique case (state_q)
				G_P4: begin
					lcg_q <= acc_q + LCG_ADD;
					mwc_q <= prod_q + {32'b0, mwc_q[63:32]};
					xs_q  <= xs_next;
				end
				G_P5: begin
					// seeding chains the three parts after each of its first two steps
					unique case (seed_cnt_q)
						2'd3: begin
							xs_q       <= lcg_q;
							seed_cnt_q <= 2'd2;
						end
						2'd2: begin
							mwc_q      <= xs_q;
							seed_cnt_q <= 2'd1;
						end
						2'd1: begin
							seed_cnt_q <= 2'd0;
						end
						default: begin
							ks_q <= res_byte;
						end
					endcase
				end
				G_IDLE, G_P0, G_P1, G_P2, G_P3: begin
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		stat.busy    = state_q != G_IDLE;
		stat.seeding = seed_cnt_q != 2'd0;
		stat.ks_byte = ks_q;
	end

endmodule

// File: rtl/fsd_back.sv
// Execution side: feedback ring, byte indices, output register, and
// requests to the keystream generator. Depends on fsd_pkg.
module fsd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  fsd_pkg::cmd_t      head,
	output logic               pop,
	input  fsd_pkg::key_arr_t  key,
	input  logic [63:0]        tweak,
	output fsd_pkg::gen_req_t  gen_req,
	output logic [63:0]        gen_seed,
	output logic [7:0]         gen_first_ks,
	input  fsd_pkg::gen_stat_t gen_stat,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         out_data
);
	import fsd_pkg::*;

	logic [7:0]            ring_q [RING_DEPTH];
	logic [RING_IDX_W-1:0] idx_q;
	logic [BIW_W-1:0]      biw_q;
	logic                  owed_q;
	logic                  out_valid_q;
	logic [7:0]            out_data_q;
	logic                  slot_free;
	logic                  ks_ready;
	logic                  go;
	logic                  do_restart;
	logic                  do_dec;
	logic [7:0]            ks;
	logic [7:0]            plain;

	assign slot_free = !out_valid_q || out_ready;
	// keystream byte is stale while a step is owed or a non-seeding step is running
	assign ks_ready  = !(owed_q || (gen_stat.busy && !gen_stat.seeding));

	always_comb begin
		unique case (head.op)
			OP_RESTART: go = 1'b1;
			OP_DECRYPT: go = slot_free && (biw_q != '0 || ks_ready);
			default:    go = 1'b0;
		endcase
	end

	assign pop        = head_valid && go;
	assign do_restart = pop && head.op == OP_RESTART;
	assign do_dec     = pop && head.op == OP_DECRYPT;

	assign gen_req.seed_load = do_restart;
	assign gen_req.start     = owed_q && !gen_stat.busy && !do_restart;
	assign gen_seed          = key[0] ^ tweak;
	assign gen_first_ks      = key[0][7:0];

	assign ks    = (biw_q == '0) ? gen_stat.ks_byte : 8'd0;
	assign plain = ks ^ head.data ^ ring_q[idx_q];

	for (genvar i = 0; i < RING_DEPTH; i++) begin : g_ring
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ring_q[i] <= '0;
			end else if (do_restart) begin
				ring_q[i] <= key[i / WORD_BYTES][8 * (i % WORD_BYTES) +: 8];
			end else if (do_dec && idx_q == RING_IDX_W'(i)) begin
				ring_q[i] <= head.data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			biw_q       <= '0;
			owed_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_restart) begin
				idx_q  <= '0;
				biw_q  <= '0;
				owed_q <= 1'b0;
			end else begin
				if (do_dec) begin
					idx_q <= idx_q + 1'b1;
					biw_q <= biw_q + 1'b1;
				end
				// first byte of a word consumed: the next word can be made now
				if (do_dec && biw_q == '0) begin
					owed_q <= 1'b1;
				end else if (gen_req.start) begin
					owed_q <= 1'b0;
				end
			end
			if (do_dec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_dec) begin
			out_data_q <= plain;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// File: rtl/feedback_stream_decryptor.sv
// Top level of the feedback stream decryptor: configuration registers,
// front queue, execution side and keystream generator.
// Depends on fsd_pkg, fsd_front, fsd_back, fsd_gen and the macros header.
//
// Channel    Dir  Handshake            Payload
// s_*        in   s_tvalid / s_tready  s_tdata = cipher_byte, s_tuser = action
// m_*        out  m_tvalid / m_tready  m_tdata = plain_byte
// cfg_*      in   cfg_wen              cfg_index, cfg_wdata (64-bit key/tweak)
//
// The back end takes decrypt items back to back while the output slot is free.
// Taking a word's first byte starts the step for the next word on the shared
// multiplier, so a steady run never waits for it. A restart is taken as soon as
// it heads the queue; its seeding steps run behind it and the next step follows
// them, so the ninth byte after a restart waits for both.
// Reset clears ring, indices, generator and queue; a four-item queue absorbs stalls.
`include "feedback_stream_decryptor_macros.svh"

module feedback_stream_decryptor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] cipher_byte
	input  logic        s_tuser,   // [0] action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata    // [7:0] plain_byte
);
	import fsd_pkg::*;

	key_arr_t    key_q;
	logic [63:0] tweak_q;
	logic        head_valid;
	cmd_t        head;
	logic        pop;
	gen_req_t    gen_req;
	gen_stat_t   gen_stat;
	logic [63:0] gen_seed;
	logic [7:0]  gen_first_ks;

	// Configuration: to be written only while idle by the user, not enforced; read by the back end at restart.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q   <= '0;
			tweak_q <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_KEY0:  key_q[0] <= cfg_wdata;
				REG_KEY1:  key_q[1] <= cfg_wdata;
				REG_KEY2:  key_q[2] <= cfg_wdata;
				REG_KEY3:  key_q[3] <= cfg_wdata;
				REG_TWEAK: tweak_q  <= cfg_wdata;
				default: begin
					// drop writes beyond the register list
				end
			endcase
		end
	end

	// Front: accept and classify, hold in a short queue.
	fsd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	// Back: ring update, plain byte, output register.
	fsd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.key          (key_q),
		.tweak        (tweak_q),
		.gen_req      (gen_req),
		.gen_seed     (gen_seed),
		.gen_first_ks (gen_first_ks),
		.gen_stat     (gen_stat),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_data     (m_tdata)
	);

	// Generator: produces the next keystream byte ahead of need.
	fsd_gen u_gen (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (gen_req),
		.seed     (gen_seed),
		.first_ks (gen_first_ks),
		.stat     (gen_stat)
	);

	// never start a step on top of a running one
	`FSD_ASSERT_IMP(a_start_when_idle, gen_stat.busy, !gen_req.start)
	// a restart always leaves the generator seeding
	`FSD_ASSERT_NEXT(a_restart_seeds, gen_req.seed_load, gen_stat.seeding && gen_stat.busy)
	// a rise of the output valid only ever follows a decrypt taken from the queue
	`FSD_ASSERT_IMP(a_out_from_decrypt, $rose(m_tvalid), $past(pop && head.op == OP_DECRYPT))

endmodule

// File: bench/tb_feedback_stream_decryptor.sv
// Self-checking bench for the feedback stream decryptor: directed and random byte streams.
// Depends on fsd_pkg and the feedback_stream_decryptor top level; refers to no other file directly.
// Predicts every plain byte from its own copy of the ring and the keystream generator.
module tb_feedback_stream_decryptor;
	timeunit 1ns;
	timeprecision 1ps;

	import fsd_pkg::*;

	// Generator constants, written out here so that a wrong package value cannot hide
	localparam logic [63:0] TB_LCG_MUL = 64'd2862933555777941757;
	localparam logic [63:0] TB_LCG_ADD = 64'd7046029254386353087;
	localparam logic [63:0] TB_MWC_MUL = 64'd4294957665;
	localparam logic [63:0] TB_XS_INIT = 64'd4101842887655102017;

	// Cycles to let pass after the last plain byte before touching the registers:
	// covers items still queued and the seeding that trails a restart
	localparam int SETTLE_CYCLES = 48;
	// Cycles with no item moving on either side before the run is declared hung
	localparam int STALL_LIMIT   = 2000;

	typedef enum int {
		KEYS_ZERO,
		KEYS_ONES,
		KEYS_RANDOM,
		KEYS_SPARSE
	} key_style_t;

	// Tracks the decryptor state item by item and holds the plain bytes still owed
	class plain_byte_predictor;
		logic [63:0] key_regs [5];
		logic [7:0]  ring [32];
		logic [4:0]  ring_pos;
		logic [2:0]  word_byte;
		logic [63:0] ks_word;
		logic [63:0] lcg;
		logic [63:0] xs;
		logic [63:0] mwc;
		logic [7:0]  expected_plain [$];
		int          mismatches;
		int          checked;

		function new();
			for (int i = 0; i < 5; i++) key_regs[i] = '0;
			for (int i = 0; i < 32; i++) ring[i] = '0;
			ring_pos   = '0;
			word_byte  = '0;
			ks_word    = '0;
			lcg        = '0;
			xs         = '0;
			mwc        = '0;
			mismatches = 0;
			checked    = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [63:0] value);
			if (idx <= REG_TWEAK)
				key_regs[idx] = value;
		endfunction

		function logic [63:0] next_word();
			logic [63:0] x;
			lcg = lcg * TB_LCG_MUL + TB_LCG_ADD;
			xs  = xs ^ (xs >> 17);
			xs  = xs ^ (xs << 31);
			xs  = xs ^ (xs >> 8);
			mwc = TB_MWC_MUL * {32'd0, mwc[31:0]} + {32'd0, mwc[63:32]};
			x   = lcg ^ (lcg << 21);
			x   = x ^ (x >> 35);
			x   = x ^ (x << 4);
			return (x + xs) ^ mwc;
		endfunction

		function void seed_gen(logic [63:0] s);
			xs  = TB_XS_INIT;
			mwc = 64'd1;
			lcg = xs ^ s;
			void'(next_word());
			xs  = lcg;
			void'(next_word());
			mwc = xs;
			void'(next_word());
		endfunction

		function void take_item(op_t act, logic [7:0] cipher);
			logic [7:0] old;
			logic [7:0] ks;
			if (act == OP_RESTART) begin
				for (int w = 0; w < 4; w++)
					for (int i = 0; i < 8; i++)
						ring[8 * w + i] = key_regs[w][8 * i +: 8];
				ks_word   = key_regs[REG_KEY0];
				ring_pos  = '0;
				word_byte = '0;
				seed_gen(key_regs[REG_KEY0] ^ key_regs[REG_TWEAK]);
			end else begin
				old            = ring[ring_pos];
				ring[ring_pos] = cipher;
				ks             = (word_byte == 3'd0) ? ks_word[7:0] : 8'h00;
				expected_plain = {expected_plain, ks ^ cipher ^ old};
				ring_pos = ring_pos + 5'd1;
				if (word_byte == 3'd7) begin
					ks_word   = next_word();
					word_byte = '0;
				end else begin
					word_byte = word_byte + 3'd1;
				end
			end
		endfunction

		function void check_plain(logic [7:0] got);
			logic [7:0] want;
			checked++;
			if (expected_plain.size() == 0) begin
				mismatches++;
				$display("%0t: plain byte mismatch: expected none, got %02h", $time, got);
			end else begin
				want = expected_plain.pop_front();
				if (want !== got) begin
					mismatches++;
					$display("%0t: plain byte mismatch: expected %02h, got %02h",
						$time, want, got);
				end
			end
		endfunction

		function int pending();
			return expected_plain.size();
		endfunction
	endclass

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_wen   = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [63:0] cfg_wdata = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = '0;   // [7:0] cipher_byte
	logic        s_tuser   = 1'b0; // [0] action
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [7:0]  m_tdata;          // [7:0] plain_byte

	plain_byte_predictor sb = new();

	int send_idle    = 0;
	int recv_idle    = 0;
	int stall_cycles = 0;
	int items_sent   = 0;
	int restarts     = 0;
	int settings     = 0;

	feedback_stream_decryptor dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Receiver: drop tready at random, one decision per falling edge
	always @(negedge clk) begin
		m_tready = ($urandom_range(99) >= recv_idle);
	end

	// Monitor and watchdog: note accepted items, check plain bytes, count dead cycles.
	// Input and output are both handled here so their order within an edge is fixed.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (s_tvalid && s_tready)
				sb.take_item(op_t'(s_tuser), s_tdata);
			if (m_tvalid && m_tready)
				sb.check_plain(m_tdata);
			if (stall_cycles >= STALL_LIMIT) begin
				$display("tb: timeout after %0d cycles with no item moving", STALL_LIMIT);
				$display("tb: failure");
				$finish;
			end
		end
	end

	// Present one item, idling first at the sender's rate; return at the falling
	// edge after acceptance with tvalid still high, so the next item follows directly
	task automatic send_item(op_t act, logic [7:0] cipher);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = act;
		s_tdata  = cipher;
		do @(posedge clk); while (!s_tready);
		items_sent++;
		if (act == OP_RESTART)
			restarts++;
		@(negedge clk);
	endtask

	// Hold the sender off until every plain byte is in, then let the block settle
	task automatic wait_idle();
		s_tvalid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Write one register; leaves cfg_wen high, the caller lowers it after a batch
	task automatic write_register(logic [2:0] idx, logic [63:0] value);
		cfg_wen   = 1'b1;
		cfg_index = idx;
		cfg_wdata = value;
		@(posedge clk);
		sb.set_reg(idx, value);
		@(negedge clk);
	endtask

	task automatic program_keys(key_style_t style);
		logic [63:0] value;
		for (int r = REG_KEY0; r <= REG_TWEAK; r++) begin
			case (style)
				KEYS_ZERO:   value = '0;
				KEYS_ONES:   value = '1;
				KEYS_SPARSE: value = 64'd1 << $urandom_range(63);
				default:     value = {$urandom, $urandom};
			endcase
			write_register(r[2:0], value);
		end
		// Indexes past the tweak must be ignored
		if ($urandom_range(1) == 0)
			write_register(3'($urandom_range(7, REG_TWEAK + 1)), {$urandom, $urandom});
		cfg_wen = 1'b0;
		settings++;
	endtask

	function automatic logic [7:0] pick_cipher();
		int roll;
		roll = $urandom_range(99);
		if (roll < 10)
			return 8'h00;
		if (roll < 20)
			return 8'hff;
		return 8'($urandom);
	endfunction

	// Mostly runs of decrypts behind a restart, long enough now and then to wrap the
	// ring; a few stray restarts cut runs short, and some streams carry on the old state
	task automatic run_stream(int n_items, int restart_first_pct);
		int sent;
		int run_left;
		sent     = 0;
		run_left = $urandom_range(30, 1);
		if ($urandom_range(99) < restart_first_pct)
			run_left = 0;
		while (sent < n_items) begin
			if (run_left == 0 || $urandom_range(99) < 4) begin
				send_item(OP_RESTART, 8'($urandom));
				run_left = ($urandom_range(9) == 0) ? $urandom_range(100, 40)
					: $urandom_range(40, 1);
			end else begin
				send_item(OP_DECRYPT, pick_cipher());
				run_left--;
			end
			sent++;
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// Directed part, no idling.
		// Decrypt straight out of reset: zero ring, zero keystream and an all-zero
		// generator; nine bytes cross the first word boundary
		send_item(OP_DECRYPT, 8'h00);
		send_item(OP_DECRYPT, 8'hff);
		repeat (7) send_item(OP_DECRYPT, 8'($urandom));
		wait_idle();

		// All-ones keys and tweak: the seed comes out as zero
		program_keys(KEYS_ONES);
		send_item(OP_RESTART, 8'h00);
		send_item(OP_DECRYPT, 8'h00);
		send_item(OP_DECRYPT, 8'hff);
		send_item(OP_DECRYPT, 8'h5a);
		send_item(OP_DECRYPT, 8'ha5);
		send_item(OP_DECRYPT, 8'($urandom));
		wait_idle();

		// All-ones seed
		write_register(REG_TWEAK, '0);
		cfg_wen = 1'b0;
		send_item(OP_RESTART, 8'hff);
		send_item(OP_DECRYPT, 8'h00);
		send_item(OP_DECRYPT, 8'hff);
		send_item(OP_DECRYPT, 8'($urandom));
		wait_idle();

		// Key writes after a restart: the running stream must not see them
		// until the next restart
		write_register(REG_KEY0, '0);
		write_register(REG_KEY1, {$urandom, $urandom});
		cfg_wen = 1'b0;
		repeat (4) send_item(OP_DECRYPT, 8'($urandom));
		send_item(OP_RESTART, 8'h00);
		send_item(OP_DECRYPT, 8'($urandom));

		// Random part: three idling profiles, five key settings in each
		for (int p = 0; p < 3; p++) begin
			case (p)
				0: begin
					send_idle = 23;
					recv_idle = 60;
				end
				1: begin
					send_idle = 60;
					recv_idle = 23;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			for (int ph = 0; ph < 5; ph++) begin
				wait_idle();
				case (ph)
					0: program_keys(KEYS_ZERO);
					1: program_keys(KEYS_ONES);
					default: program_keys(($urandom_range(1) == 0) ? KEYS_RANDOM
						: KEYS_SPARSE);
				endcase
				run_stream(50, 85);
			end
		end

		// Drain, then allow for anything the block might still push out
		wait_idle();
		$display("tb: %0d items sent (%0d restarts) across %0d key settings",
			items_sent, restarts, settings);
		$display("tb: %0d plain bytes checked, %0d mismatches",
			sb.checked, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl
rtl/fsd_pkg.sv
rtl/fsd_front.sv
rtl/fsd_gen.sv
rtl/fsd_back.sv
rtl/feedback_stream_decryptor.sv
bench/tb_feedback_stream_decryptor.sv
